// ----- sv/hcid_pkg.sv -----
// shared types and codes for the hci h4 uart deframer
`default_nettype none
package hcid_pkg;

  localparam logic [7:0] TYPE_EVENT = 8'h04;
  localparam logic [7:0] TYPE_ACL   = 8'h02;

  localparam int CNT_W = 17;

  // completed item kind
  typedef enum logic [1:0] {
    KIND_EVENT  = 2'd0,
    KIND_ACL    = 2'd1,
    KIND_SIGNAL = 2'd2
  } kind_t;

  // packet buffer select
  localparam logic BUF_EVENT = 1'b0;
  localparam logic BUF_ACL   = 1'b1;

  // one result item
  typedef struct packed {
    logic             write_enable;
    logic             buffer_select;
    logic [CNT_W-1:0] write_index;
    logic [7:0]       write_data;
    logic             packet_done;
    kind_t            done_kind;
    logic [7:0]       signal_byte;
  } res_t;

endpackage
`default_nettype wire

// ----- sv/hci_uart_packet_deframer.sv -----
// top level of the hci h4 uart packet deframer
//
//  channel | dir | fields
//  s_*     | in  | tdata[7:0] rx_byte
//  m_*     | out | tdata: write_index, write_data, signal_byte; tlast: packet_done;
//          |     | tuser: write_enable, buffer_select, done_kind
//
// one byte per cycle; each accepted byte yields its result in the next cycle from
// the result register. s_tready is high whenever the result register is empty
// or being drained, so bytes stream back to back under a ready sink.
// rst is synchronous and returns the framer to idle awaiting a type byte.
// a stalled m_tready holds the result and stalls the input side.
`default_nettype none
module hci_uart_packet_deframer
  import hcid_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [16:0] write_index, [24:17] write_data,
                                      // [32:25] signal_byte, [39:33] zero
  output logic             m_tlast,   // packet_done
  output logic [3:0]       m_tuser    // [0] write_enable, [1] buffer_select,
                                      // [3:2] done_kind
);

  logic take;
  res_t res_c;
  res_t res_q;

  // accept while the result register is free or draining
  assign s_tready = !m_tvalid || m_tready;
  assign take     = s_tvalid && s_tready;

  hcid_core u_core (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .rx_byte (s_tdata),
    .res     (res_c)
  );

  hcid_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (take),
    .res_in   (res_c),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .res_out  (res_q)
  );

  // pack result fields onto the stream
  assign m_tdata = {7'd0, res_q.signal_byte, res_q.write_data, res_q.write_index};
  assign m_tlast = res_q.packet_done;
  assign m_tuser = {res_q.done_kind, res_q.buffer_select, res_q.write_enable};

endmodule
`default_nettype wire

// ----- sv/hcid_core.sv -----
// framing state and per-byte decode of the h4 stream
`default_nettype none
module hcid_core
  import hcid_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       take,
  input  wire logic [7:0] rx_byte,
  output res_t            res
);

  logic             in_packet, in_packet_next;
  logic             packet_kind, packet_kind_next;
  logic [CNT_W-1:0] body_count, body_count_next;
  logic [CNT_W-1:0] target_count, target_count_next;
  logic [7:0]       previous_byte, previous_byte_next;

  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] evt_len;
  logic [CNT_W-1:0] acl_len;
  logic             done;

  assign n       = body_count + CNT_W'(1);
  assign evt_len = CNT_W'(rx_byte) + CNT_W'(2);
  assign acl_len = CNT_W'({rx_byte, previous_byte}) + CNT_W'(4);

  // decode one byte and compute next framing state
  always_comb begin
    in_packet_next     = in_packet;
    packet_kind_next   = packet_kind;
    body_count_next    = body_count;
    target_count_next  = target_count;
    previous_byte_next = previous_byte;
    done               = 1'b0;
    res                = '0;

    if (!in_packet) begin
      if (rx_byte == TYPE_EVENT || rx_byte == TYPE_ACL) begin
        in_packet_next     = 1'b1;
        packet_kind_next   = (rx_byte == TYPE_ACL);
        body_count_next    = '0;
        target_count_next  = '0;
        previous_byte_next = '0;
      end else begin
        res.packet_done = 1'b1;
        res.done_kind   = KIND_SIGNAL;
        res.signal_byte = rx_byte;
      end
    end else begin
      res.write_enable  = 1'b1;
      res.buffer_select = packet_kind;
      res.write_index   = body_count;
      res.write_data    = rx_byte;

      // length bytes set the target, otherwise compare against it
      if (packet_kind == BUF_EVENT && n == CNT_W'(2)) begin
        target_count_next = evt_len;
        done              = (evt_len == n);
      end else if (packet_kind == BUF_ACL && n == CNT_W'(4)) begin
        target_count_next = acl_len;
        done              = (acl_len == n);
      end else begin
        done = (target_count != '0) && (n == target_count);
      end
      body_count_next    = n;
      previous_byte_next = rx_byte;

      if (done) begin
        res.packet_done   = 1'b1;
        res.done_kind     = packet_kind ? KIND_ACL : KIND_EVENT;
        in_packet_next    = 1'b0;
        body_count_next   = '0;
        target_count_next = '0;
      end
    end
  end

  // state update on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      in_packet     <= 1'b0;
      packet_kind   <= 1'b0;
      body_count    <= '0;
      target_count  <= '0;
      previous_byte <= '0;
    end else if (take) begin
      in_packet     <= in_packet_next;
      packet_kind   <= packet_kind_next;
      body_count    <= body_count_next;
      target_count  <= target_count_next;
      previous_byte <= previous_byte_next;
    end
  end

endmodule
`default_nettype wire

// ----- sv/hcid_out_reg.sv -----
// result register feeding the master stream
`default_nettype none
module hcid_out_reg
  import hcid_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic load,
  input  wire res_t res_in,
  input  wire logic m_tready,
  output logic      m_tvalid,
  output res_t      res_out
);

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule
`default_nettype wire

// ----- sim/hci_uart_packet_deframer_chk.sv -----
// transfer monitor, deframing predictor and result checker for the hci h4 deframer
`timescale 1ns / 100ps
module hci_uart_packet_deframer_chk
  import hcid_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // [16:0] write_index, [24:17] write_data,
                                 // [32:25] signal_byte, [39:33] zero
  input  logic        m_tlast,   // packet_done
  input  logic [3:0]  m_tuser,   // [0] write_enable, [1] buffer_select, [3:2] done_kind
  output int          mismatches,
  output int          pending
);

  // body position at which each packet type knows its total length
  localparam int EVT_LEN_POS = 2;
  localparam int ACL_LEN_POS = 4;

  // framer state as seen by the predictor
  logic             in_pkt;
  logic             pkt_acl;
  logic [CNT_W-1:0] body_cnt;
  logic [CNT_W-1:0] target_cnt;
  logic [7:0]       prev_byte;

  res_t expected_results[$];
  int   result_num;

  // works out the result of one received byte and advances the framer state
  function automatic res_t deframe_byte(input logic [7:0] b);
    res_t             r;
    logic [CNT_W-1:0] n;
    logic             finished;
    r = '0;
    finished = 1'b0;
    if (!in_pkt) begin
      if (b == TYPE_EVENT || b == TYPE_ACL) begin
        in_pkt = 1'b1;
        pkt_acl = (b == TYPE_ACL);
        body_cnt = '0;
        target_cnt = '0;
        prev_byte = '0;
      end else begin
        // unknown first byte goes out as a signal byte
        r.packet_done = 1'b1;
        r.done_kind = KIND_SIGNAL;
        r.signal_byte = b;
      end
    end else begin
      r.write_enable = 1'b1;
      r.buffer_select = pkt_acl ? BUF_ACL : BUF_EVENT;
      r.write_index = body_cnt;
      r.write_data = b;
      n = body_cnt + CNT_W'(1);
      if (!pkt_acl && n == CNT_W'(EVT_LEN_POS)) begin
        target_cnt = CNT_W'(b);
        target_cnt = target_cnt + CNT_W'(EVT_LEN_POS);
        finished = (target_cnt == n);
      end else if (pkt_acl && n == CNT_W'(ACL_LEN_POS)) begin
        // little-endian length, low byte came just before
        target_cnt = CNT_W'({b, prev_byte});
        target_cnt = target_cnt + CNT_W'(ACL_LEN_POS);
        finished = (target_cnt == n);
      end else if (target_cnt != '0 && n == target_cnt) begin
        finished = 1'b1;
      end
      body_cnt = n;
      prev_byte = b;
      if (finished) begin
        r.packet_done = 1'b1;
        r.done_kind = pkt_acl ? KIND_ACL : KIND_EVENT;
        in_pkt = 1'b0;
        body_cnt = '0;
        target_cnt = '0;
      end
    end
    return r;
  endfunction

  // compare finished results first, then queue the prediction for the new byte
  always @(posedge clk) begin
    res_t got, want;
    if (rst) begin
      in_pkt = 1'b0;
      pkt_acl = 1'b0;
      body_cnt = '0;
      target_cnt = '0;
      prev_byte = '0;
      expected_results.delete();
      mismatches = 0;
      pending = 0;
      result_num = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.write_enable = m_tuser[0];
        got.buffer_select = m_tuser[1];
        got.done_kind = kind_t'(m_tuser[3:2]);
        got.write_index = m_tdata[16:0];
        got.write_data = m_tdata[24:17];
        got.signal_byte = m_tdata[32:25];
        got.packet_done = m_tlast;
        if (expected_results.size() == 0) begin
          if (mismatches < 10)
            $display("result %0d arrived with no byte waiting for it", result_num);
          mismatches = mismatches + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            if (mismatches < 10)
              $display({"result %0d: want we=%b buf=%b idx=%0d data=%h done=%b kind=%0d ",
                        "sig=%h / got we=%b buf=%b idx=%0d data=%h done=%b kind=%0d sig=%h"},
                       result_num, want.write_enable, want.buffer_select, want.write_index,
                       want.write_data, want.packet_done, want.done_kind, want.signal_byte,
                       got.write_enable, got.buffer_select, got.write_index,
                       got.write_data, got.packet_done, got.done_kind, got.signal_byte);
            mismatches = mismatches + 1;
          end
        end
        result_num = result_num + 1;
      end
      if (s_tvalid && s_tready)
        expected_results.push_back(deframe_byte(s_tdata));
      pending = expected_results.size();
    end
  end

endmodule

// ----- sim/hci_uart_packet_deframer_tb.sv -----
// stimulus, stall generation and verdict for the hci h4 deframer
`timescale 1ns / 100ps
module hci_uart_packet_deframer_tb;
  import hcid_pkg::*;

  // cycles with no transfer on either side before the run is abandoned
  localparam int QUIET_LIMIT = 500;
  localparam int RANDOM_BYTES = 1620;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] rx_byte
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // [16:0] write_index, [24:17] write_data, [32:25] signal_byte
  logic        m_tlast;   // packet_done
  logic [3:0]  m_tuser;   // [0] write_enable, [1] buffer_select, [3:2] done_kind

  int mismatches;
  int pending;
  int bytes_sent;
  int src_idle_max;
  int quiet_cycles;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  hci_uart_packet_deframer DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  hci_uart_packet_deframer_chk checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // one byte over the input channel, after a random gap
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = $urandom_range(0, src_idle_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // event packet: type, code, length, then length payload bytes
  task automatic send_event(input logic [7:0] code, input logic [7:0] len);
    send_byte(TYPE_EVENT);
    send_byte(code);
    send_byte(len);
    for (int i = 0; i < len; i++) send_byte(8'($urandom));
  endtask

  // acl packet: type, 16-bit handle, little-endian length, then payload
  task automatic send_acl(input logic [15:0] handle, input logic [15:0] len);
    send_byte(TYPE_ACL);
    send_byte(handle[7:0]);
    send_byte(handle[15:8]);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    for (int i = 0; i < len; i++) send_byte(8'($urandom));
  endtask

  // result sink with random stalls, calm stretches now and then
  initial begin
    int stall;
    int sink_idle_max;
    m_tready <= 1'b0;
    sink_idle_max = 7;
    forever begin
      stall = $urandom_range(0, sink_idle_max);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      if ($urandom_range(0, 39) == 0)
        sink_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 7;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("** hci_uart_packet_deframer: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    int start;
    int pick;
    logic [7:0] b;
    logic [15:0] len16;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    bytes_sent = 0;
    src_idle_max = 7;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: signal bytes, zero and short packets of both types
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_event(8'hFF, 8'd0);
    send_event(8'h0E, 8'd1);
    send_acl(16'hFFFF, 16'd0);
    send_acl(16'h0001, 16'd2);

    // longest event packet
    src_idle_max = 1;
    send_event(8'h3E, 8'd255);

    // random: mostly well-formed packets, some signal bytes between them
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      src_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        b = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 20));
        send_event(8'($urandom), b);
      end else if (pick < 85) begin
        len16 = ($urandom_range(0, 24) == 0) ? 16'($urandom_range(0, 511))
                                             : 16'($urandom_range(0, 24));
        send_acl(16'($urandom), len16);
      end else begin
        // noise: never a type byte, so framing stays bounded
        do b = 8'($urandom); while (b == TYPE_EVENT || b == TYPE_ACL);
        send_byte(b);
      end
    end
    s_tvalid <= 1'b0;

    // drain, then a few cycles for anything stray
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("** hci_uart_packet_deframer: PASSED **");
    else
      $display("** hci_uart_packet_deframer: FAILED **");
    $finish;
  end

endmodule
